// ===== rtl/core/tfp_pkg.sv =====
// ----------------------------------------------------------------------------
// tfp_pkg
// Types and constants shared by the TLV frame parser and its result channel interface.
// ----------------------------------------------------------------------------
`default_nettype none

package tfp_pkg;

	localparam int unsigned HDR_BYTES = 4;
	localparam int unsigned HDR_POS_W = 3;

	localparam logic [HDR_POS_W-1:0] HDR_POS_LEN_HI = HDR_POS_W'(2);
	localparam logic [HDR_POS_W-1:0] HDR_POS_LEN_LO = HDR_POS_W'(3);
	localparam logic [HDR_POS_W-1:0] HDR_POS_END    = HDR_POS_W'(HDR_BYTES);

	typedef logic [2:0] role_t;

	localparam role_t ROLE_HEADER = 3'd0;
	localparam role_t ROLE_TAG    = 3'd1;
	localparam role_t ROLE_LENGTH = 3'd2;
	localparam role_t ROLE_VALUE  = 3'd3;
	localparam role_t ROLE_BEYOND = 3'd4;

	typedef enum logic [1:0] {
		PH_TAG = 2'd0,
		PH_LEN = 2'd1,
		PH_VAL = 2'd2
	} phase_t;

	typedef struct packed {
		role_t       byte_role;
		logic [7:0]  element_tag;
		logic [7:0]  element_length;
		logic [7:0]  value_byte;
		logic [7:0]  value_index;
		logic        element_done;
		logic [15:0] payload_length;
		logic        frame_done;
		logic        malformed;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/tfp_byte_if.sv =====
// ----------------------------------------------------------------------------
// tfp_byte_if
// Input channel of the TLV frame parser: one message byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfp_byte_if;

	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;

	modport source (output valid, output data_byte, output frame_end, input ready);
	modport sink (input valid, input data_byte, input frame_end, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/tfp_result_if.sv =====
// ----------------------------------------------------------------------------
// tfp_result_if
// Output channel of the TLV frame parser: one classified byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfp_result_if
	import tfp_pkg::*;
;

	logic        valid;
	logic        ready;
	role_t       byte_role;
	logic [7:0]  element_tag;
	logic [7:0]  element_length;
	logic [7:0]  value_byte;
	logic [7:0]  value_index;
	logic        element_done;
	logic [15:0] payload_length;
	logic        frame_done;
	logic        malformed;

	modport source (
		output valid, input ready,
		output byte_role, output element_tag, output element_length,
		output value_byte, output value_index, output element_done,
		output payload_length, output frame_done, output malformed
	);
	modport sink (
		input valid, output ready,
		input byte_role, input element_tag, input element_length,
		input value_byte, input value_index, input element_done,
		input payload_length, input frame_done, input malformed
	);

endinterface

`default_nettype wire

// ===== rtl/core/tlv_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// tlv_frame_parser_core
// Byte-serial parser for a framed tag-length-value message.
// ----------------------------------------------------------------------------
// The msg channel takes one byte of a received buffer per word, with
// frame_end set on the last byte. The first four bytes are the header, whose
// last two give the big-endian payload length; the payload is split into
// tag, length and value bytes.
// The res channel returns exactly one word per byte, classifying it and
// carrying the current element, the declared payload length and a sticky
// malformed flag that is the final verdict on the word with frame_done set.
// A byte is registered in the input register at acceptance and classified
// from there, and its result word is registered in the result register,
// which drives res.valid. The block takes one byte per cycle while the
// receiver takes result words; the parse state is updated in one short step per byte.
// When the receiver stalls, the result register holds and the input register
// fills, after which msg.ready drops; no word is lost or repeated.
// Reset clears the parse state so that the next byte starts a new header,
// and the state also returns to reset after each byte carrying frame_end.
// ----------------------------------------------------------------------------
`default_nettype none

module tlv_frame_parser_core
	import tfp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	tfp_byte_if.sink     msg,
	tfp_result_if.source res
);

	logic       v_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       v_s2;
	result_t    res_s2;

	logic [HDR_POS_W-1:0] hdr_pos_q, hdr_pos_n;
	logic [15:0]          decl_len_q, decl_len_n;
	logic [15:0]          pay_left_q, pay_left_n;
	phase_t               phase_q, phase_n;
	logic [7:0]           tag_q, tag_n;
	logic [7:0]           len_q, len_n;
	logic [7:0]           val_left_q, val_left_n;
	logic                 err_q, err_n;
	result_t              res_n;

	logic adv_s2;
	logic adv_s1;

	assign adv_s2    = !v_s2 || res.ready;
	assign adv_s1    = !v_s1 || adv_s2;
	assign msg.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && msg.valid) begin
			data_s1 <= msg.data_byte;
			last_s1 <= msg.frame_end;
		end
	end

	always_comb begin
		hdr_pos_n  = hdr_pos_q;
		decl_len_n = decl_len_q;
		pay_left_n = pay_left_q;
		phase_n    = phase_q;
		tag_n      = tag_q;
		len_n      = len_q;
		val_left_n = val_left_q;
		err_n      = err_q;
		res_n      = '0;
		res_n.byte_role = ROLE_BEYOND;

		if (hdr_pos_q < HDR_POS_END) begin
			res_n.byte_role = ROLE_HEADER;
			if (hdr_pos_q == HDR_POS_LEN_HI) begin
				decl_len_n = {data_s1, 8'h00};
			end else if (hdr_pos_q == HDR_POS_LEN_LO) begin
				decl_len_n = decl_len_q | {8'h00, data_s1};
				pay_left_n = decl_len_q | {8'h00, data_s1};
				phase_n    = PH_TAG;
			end
			hdr_pos_n = hdr_pos_q + HDR_POS_W'(1);
		end else if (pay_left_q != 16'd0) begin
			pay_left_n = pay_left_q - 16'd1;
			unique case (phase_q)
				PH_TAG: begin
					res_n.byte_role   = ROLE_TAG;
					res_n.element_tag = data_s1;
					tag_n             = data_s1;
					phase_n           = PH_LEN;
					if (pay_left_q == 16'd1) begin
						err_n = 1'b1;
					end
				end
				PH_LEN: begin
					res_n.byte_role      = ROLE_LENGTH;
					res_n.element_tag    = tag_q;
					res_n.element_length = data_s1;
					len_n                = data_s1;
					val_left_n           = data_s1;
					if ({8'h00, data_s1} > pay_left_n) begin
						err_n = 1'b1;
					end
					if (data_s1 == 8'd0) begin
						res_n.element_done = 1'b1;
						phase_n            = PH_TAG;
					end else begin
						phase_n = PH_VAL;
					end
				end
				default: begin
					res_n.byte_role      = ROLE_VALUE;
					res_n.element_tag    = tag_q;
					res_n.element_length = len_q;
					res_n.value_byte     = data_s1;
					res_n.value_index    = len_q - val_left_q;
					val_left_n           = val_left_q - 8'd1;
					if (val_left_q == 8'd1) begin
						res_n.element_done = 1'b1;
						phase_n            = PH_TAG;
					end
				end
			endcase
		end

		if (hdr_pos_n >= HDR_POS_END) begin
			res_n.payload_length = decl_len_n;
		end

		if (last_s1 && (hdr_pos_n < HDR_POS_END || pay_left_n != 16'd0)) begin
			err_n = 1'b1;
		end
		res_n.malformed  = err_n;
		res_n.frame_done = last_s1;

		if (last_s1) begin
			hdr_pos_n  = '0;
			decl_len_n = '0;
			pay_left_n = '0;
			phase_n    = PH_TAG;
			tag_n      = '0;
			len_n      = '0;
			val_left_n = '0;
			err_n      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q  <= '0;
			decl_len_q <= '0;
			pay_left_q <= '0;
			phase_q    <= PH_TAG;
			tag_q      <= '0;
			len_q      <= '0;
			val_left_q <= '0;
			err_q      <= 1'b0;
			v_s2       <= 1'b0;
		end else begin
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_s2 && v_s1) begin
				hdr_pos_q  <= hdr_pos_n;
				decl_len_q <= decl_len_n;
				pay_left_q <= pay_left_n;
				phase_q    <= phase_n;
				tag_q      <= tag_n;
				len_q      <= len_n;
				val_left_q <= val_left_n;
				err_q      <= err_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			res_s2 <= res_n;
		end
	end

	assign res.valid          = v_s2;
	assign res.byte_role      = res_s2.byte_role;
	assign res.element_tag    = res_s2.element_tag;
	assign res.element_length = res_s2.element_length;
	assign res.value_byte     = res_s2.value_byte;
	assign res.value_index    = res_s2.value_index;
	assign res.element_done   = res_s2.element_done;
	assign res.payload_length = res_s2.payload_length;
	assign res.frame_done     = res_s2.frame_done;
	assign res.malformed      = res_s2.malformed;

endmodule

`default_nettype wire
